// ----- hw/rtl/lva_pkg.sv -----
// Shared constants, types and command/status structs of the LRU voice allocator.
package lva_pkg;

   localparam int NUM_VOICES   = 16;
   localparam int NUM_CHANNELS = 16;

   localparam int VOICE_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int NOTE_W      = 7;
   localparam int CHAN_W      = 4;
   localparam int VEL_W       = 7;
   localparam int MASK_W      = 16;
   localparam int AGE_W       = 5;
   localparam int OUT_VOICE_W = 4;
   localparam int STATUS_W    = 3;

   localparam logic [AGE_W-1:0] AGE_MAX = '1;
   localparam logic [AGE_W-1:0] AGE_ONE = AGE_W'(1);

   localparam logic MODE_NOTE_ON  = 1'b0;
   localparam logic MODE_NOTE_OFF = 1'b1;

   typedef logic [VOICE_W-1:0] voice_idx_type;
   typedef logic [AGE_W-1:0]   age_type;
   typedef logic [NOTE_W-1:0]  note_type;
   typedef logic [CHAN_W-1:0]  chan_type;
   typedef logic [VEL_W-1:0]   vel_type;
   typedef logic [MASK_W-1:0]  mask_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_REUSED      = 3'd0,
      ST_FREE        = 3'd1,
      ST_STOLEN      = 3'd2,
      ST_OFF_FOUND   = 3'd3,
      ST_OFF_MISSING = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;      // latch the accepted event and clear the search results
      logic free_step;    // release one finished voice at the sweep index
      logic search_step;  // examine one voice at the sweep index
      logic update;       // apply ages and claim the chosen voice
      logic load_rsp;     // load the result register
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic chan_ok;      // event channel is within range
      logic note_off;     // event is a note off
      logic last;         // sweep index is at the last voice
   } dp_status_type;

endpackage

// ----- hw/rtl/lva_req_if.sv -----
// Event channel of the voice allocator: valid/ready handshake with the event fields.
interface lva_req_if import lva_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     mode;
   note_type note;
   chan_type channel;
   vel_type  velocity;
   mask_type idle_mask;

   modport source (output valid, output mode, output note, output channel,
                   output velocity, output idle_mask, input ready);
   modport sink   (input valid, input mode, input note, input channel,
                   input velocity, input idle_mask, output ready);
endinterface

// ----- hw/rtl/lva_rsp_if.sv -----
// Result channel of the voice allocator: valid/ready handshake with the result fields.
interface lva_rsp_if import lva_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OUT_VOICE_W-1:0] voice;
   logic [STATUS_W-1:0]    status;
   note_type               trigger_note;
   vel_type                trigger_velocity;

   modport source (output valid, output voice, output status, output trigger_note,
                   output trigger_velocity, input ready);
   modport sink   (input valid, input voice, input status, input trigger_note,
                   input trigger_velocity, output ready);
endinterface

// ----- hw/rtl/lva_datapath.sv -----
// Voice table, sweep index, search registers and result register of the allocator.
module lva_datapath import lva_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   input  logic                   req_mode,
   input  note_type               req_note,
   input  chan_type               req_channel,
   input  vel_type                req_velocity,
   input  mask_type               req_idle_mask,
   output dp_status_type          status,
   output logic [OUT_VOICE_W-1:0] rsp_voice,
   output logic [STATUS_W-1:0]    rsp_status,
   output note_type               rsp_trigger_note,
   output vel_type                rsp_trigger_velocity
);

   // Latched event.
   logic     mode_ff;
   note_type note_ff;
   chan_type chan_ff;
   vel_type  vel_ff;
   mask_type idle_ff;

   // Sweep index.
   voice_idx_type idx_ff, idx_in;

   // Voice table, one lane per voice.
   logic     valid_ff   [NUM_VOICES];
   logic     valid_in   [NUM_VOICES];
   note_type vnote_ff   [NUM_VOICES];
   note_type vnote_in   [NUM_VOICES];
   chan_type vchan_ff   [NUM_VOICES];
   chan_type vchan_in   [NUM_VOICES];
   age_type  age_ff     [NUM_VOICES];
   age_type  age_in     [NUM_VOICES];

   // Search results.
   logic          same_found_ff, first_found_ff, free_found_ff;
   voice_idx_type same_idx_ff, first_idx_ff, free_idx_ff, oldest_idx_ff;
   age_type       same_age_ff, oldest_age_ff;

   // Result register.
   logic [OUT_VOICE_W-1:0] voice_ff;
   status_type             status_ff;
   note_type               tnote_ff;
   vel_type                tvel_ff;

   logic          cur_valid, cur_hold, idle_bit, last;
   age_type       cur_age;
   logic [31:0]   idx_wide;
   voice_idx_type chosen;
   voice_idx_type off_idx;
   status_type    rsp_code;

   assign idx_wide  = 32'(idx_ff);
   assign cur_valid = valid_ff[idx_ff];
   assign cur_age   = age_ff[idx_ff];
   assign cur_hold  = cur_valid && (vnote_ff[idx_ff] == note_ff) && (vchan_ff[idx_ff] == chan_ff);
   // The finished-voice mask only reaches the first sixteen voices.
   assign idle_bit  = (idx_wide < 32'd16) && idle_ff[idx_wide[3:0]];
   assign last      = (idx_wide == 32'(NUM_VOICES - 1));

   assign status.chan_ok  = (32'(chan_ff) < 32'(NUM_CHANNELS));
   assign status.note_off = (mode_ff == MODE_NOTE_OFF);
   assign status.last     = last;

   always_comb begin
      if (same_found_ff) begin
         chosen = same_idx_ff;
      end else if (free_found_ff) begin
         chosen = free_idx_ff;
      end else begin
         chosen = oldest_idx_ff;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.capture) begin
         idx_in = '0;
      end else if (cmd.free_step || cmd.search_step) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      vnote_in = vnote_ff;
      vchan_in = vchan_ff;
      age_in   = age_ff;
      if (cmd.free_step && idle_bit) begin
         valid_in[idx_ff] = 1'b0;
         if (cur_age != '0) begin
            for (int k = 0; k < NUM_VOICES; k++) begin
               if (age_ff[k] > cur_age) begin
                  age_in[k] = age_ff[k] - 1'b1;
               end
            end
            age_in[idx_ff] = '0;
         end
      end
      if (cmd.update) begin
         for (int k = 0; k < NUM_VOICES; k++) begin
            if (VOICE_W'(k) == chosen) begin
               age_in[k]   = AGE_ONE;
               valid_in[k] = 1'b1;
               vnote_in[k] = note_ff;
               vchan_in[k] = chan_ff;
            end else if (valid_ff[k] && (!same_found_ff || (same_age_ff > age_ff[k]))
                         && (age_ff[k] != AGE_MAX)) begin
               age_in[k] = age_ff[k] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         for (int k = 0; k < NUM_VOICES; k++) begin
            valid_ff[k] <= 1'b0;
            vnote_ff[k] <= '0;
            vchan_ff[k] <= '0;
            age_ff[k]   <= '0;
         end
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
         vnote_ff <= vnote_in;
         vchan_ff <= vchan_in;
         age_ff   <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         note_ff <= req_note;
         chan_ff <= req_channel;
         vel_ff  <= req_velocity;
         idle_ff <= req_idle_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         same_found_ff  <= 1'b0;
         first_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else if (cmd.capture) begin
         same_found_ff  <= 1'b0;
         first_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else if (cmd.search_step) begin
         if (cur_hold) begin
            same_found_ff <= 1'b1;
            if (!first_found_ff) begin
               first_found_ff <= 1'b1;
            end
         end
         if (!cur_valid) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         same_idx_ff   <= '0;
         same_age_ff   <= '0;
         first_idx_ff  <= '0;
         free_idx_ff   <= '0;
         oldest_idx_ff <= '0;
         oldest_age_ff <= '0;
      end else if (cmd.search_step) begin
         if (cur_hold) begin
            same_idx_ff <= idx_ff;
            same_age_ff <= cur_age;
            if (!first_found_ff) begin
               first_idx_ff <= idx_ff;
            end
         end
         if (!cur_valid) begin
            free_idx_ff <= idx_ff;
         end
         // Strict compare keeps the first voice among equal oldest ages.
         if (oldest_age_ff < cur_age) begin
            oldest_age_ff <= cur_age;
            oldest_idx_ff <= idx_ff;
         end
      end
   end

   assign off_idx = first_found_ff ? first_idx_ff : '0;

   always_comb begin
      if (mode_ff == MODE_NOTE_OFF) begin
         rsp_code = first_found_ff ? ST_OFF_FOUND : ST_OFF_MISSING;
      end else if (same_found_ff) begin
         rsp_code = ST_REUSED;
      end else if (free_found_ff) begin
         rsp_code = ST_FREE;
      end else begin
         rsp_code = ST_STOLEN;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         voice_ff  <= OUT_VOICE_W'((mode_ff == MODE_NOTE_OFF) ? off_idx : chosen);
         status_ff <= rsp_code;
         tnote_ff  <= note_ff;
         tvel_ff   <= (mode_ff == MODE_NOTE_OFF) ? '0 : vel_ff;
      end
   end

   assign rsp_voice            = voice_ff;
   assign rsp_status           = status_ff;
   assign rsp_trigger_note     = tnote_ff;
   assign rsp_trigger_velocity = tvel_ff;

endmodule

// ----- hw/rtl/lva_ctrl.sv -----
// Sequencer of the allocator: event capture, free sweep, search sweep, update and result.
module lva_ctrl import lva_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FREE,
      S_SEARCH,
      S_UPDATE,
      S_RESULT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.capture     = (state_ff == S_IDLE) && req_valid;
      cmd.free_step   = (state_ff == S_FREE);
      cmd.search_step = (state_ff == S_SEARCH);
      cmd.update      = (state_ff == S_UPDATE);
      cmd.load_rsp    = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               priority if (!status.chan_ok) begin
                  state_ff <= S_IDLE;
               end else if (status.note_off) begin
                  state_ff <= S_SEARCH;
               end else begin
                  state_ff <= S_FREE;
               end
            end
            S_FREE: begin
               if (status.last) begin
                  state_ff <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (status.last) begin
                  state_ff <= status.note_off ? S_RESULT : S_UPDATE;
               end
            end
            S_UPDATE: begin
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               if (cmd.load_rsp) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- hw/rtl/lru_voice_allocator.sv -----
// Top level of the LRU voice allocator: sequencer, datapath and port wiring.
//
//   Channel   Direction  Beat contents
//   req_bus   in         mode, note, channel, velocity, idle_mask
//   rsp_bus   out        voice, status, trigger_note, trigger_velocity
//
// A note-on event passes from acceptance to a loaded result through a decode
// state, a sweep that releases finished voices one index at a time, a search
// sweep over the voice table, an update state and a state that loads the
// result register. A note-off skips the release sweep and the update. The
// next beat is taken only in the idle state, after the previous event has
// loaded its result. Both sweeps share one read index into the voice table.
// An event whose channel is out of range is dropped after the decode state
// with no beat on rsp_bus.
// Reset is synchronous and clears the voice table to all voices unused with
// age zero. The result sits in an output register, so the next event is
// accepted while the previous result beat still waits for rsp_bus.ready; a
// stall on rsp_bus only holds the block in its result state.
module lru_voice_allocator import lva_pkg::*; (
   input logic       clock,
   input logic       reset,
   lva_req_if.sink   req_bus,
   lva_rsp_if.source rsp_bus
);

   ctrl_cmd_type           cmd;
   dp_status_type          dp_status;
   logic                   ctrl_req_ready;
   logic                   ctrl_rsp_valid;
   logic [OUT_VOICE_W-1:0] dp_voice;
   logic [STATUS_W-1:0]    dp_status_code;
   note_type               dp_trigger_note;
   vel_type                dp_trigger_velocity;

   // The sequencer owns the handshakes; it steps the datapath through each event.
   lva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctrl_req_ready),
      .rsp_valid (ctrl_rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   // The datapath holds the voice table and the result payload register.
   lva_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_mode             (req_bus.mode),
      .req_note             (req_bus.note),
      .req_channel          (req_bus.channel),
      .req_velocity         (req_bus.velocity),
      .req_idle_mask        (req_bus.idle_mask),
      .status               (dp_status),
      .rsp_voice            (dp_voice),
      .rsp_status           (dp_status_code),
      .rsp_trigger_note     (dp_trigger_note),
      .rsp_trigger_velocity (dp_trigger_velocity)
   );

   assign req_bus.ready            = ctrl_req_ready;
   assign rsp_bus.valid            = ctrl_rsp_valid;
   assign rsp_bus.voice            = dp_voice;
   assign rsp_bus.status           = dp_status_code;
   assign rsp_bus.trigger_note     = dp_trigger_note;
   assign rsp_bus.trigger_velocity = dp_trigger_velocity;

   // Once an event beat is taken, no further beat is taken until it is finished.
   a_one_event_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("event accepted while the previous one was still in work");

   // A new result beat only appears after the sequencer loaded the result register.
   a_result_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(cmd.load_rsp))
      else $error("result valid raised without a result load");

   // The result register is only loaded while an event is in work.
   a_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !req_bus.ready)
      else $error("result loaded while the block was idle");

   // A note-off result never carries a velocity.
   a_off_no_velocity: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status == ST_OFF_FOUND || rsp_bus.status == ST_OFF_MISSING))
      |-> (rsp_bus.trigger_velocity == '0))
      else $error("note-off result with nonzero velocity");

endmodule
